// File: hdl/rsws_pkg.sv
// ----------------------------------------------------------------------------
// rsws_pkg: shared types and constants of the rotating shift word scrambler
// Word layouts of both channels, register indexes, status codes and the
// reduction of a shift count to a rotate amount.
// ----------------------------------------------------------------------------
package rsws_pkg;

  localparam int WORD_BITS  = 18;
  localparam int SHIFT_BITS = 6;
  localparam int AMT_BITS   = $clog2(WORD_BITS);
  localparam int STAT_BITS  = 2;
  localparam int CFG_IDX_BITS = 2;

  // Subtract steps needed to bring any shift count below WORD_BITS
  localparam int MOD_STEPS  = ((1 << SHIFT_BITS) - 1) / WORD_BITS;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DECODE_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_SHIFT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SHIFT   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SHIFT   = 2'd3;

  // Request types
  localparam logic REQ_DATA   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Status codes
  localparam logic [STAT_BITS-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_START_BAD = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_SUM_BAD   = 2'd2;

  typedef struct packed {
    logic                 req_type;
    logic [WORD_BITS-1:0] word_in;
  } in_word_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word_out;
    logic                 end_of_message;
    logic [STAT_BITS-1:0] status;
  } out_word_t;

  // Shift count modulo WORD_BITS by repeated compare and subtract
  function automatic logic [AMT_BITS-1:0] rot_amount(input logic [SHIFT_BITS-1:0] shift);
    logic [SHIFT_BITS-1:0] a;
    a = shift;
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (a >= SHIFT_BITS'(WORD_BITS)) begin
        a = a - SHIFT_BITS'(WORD_BITS);
      end
    end
    return a[AMT_BITS-1:0];
  endfunction

endpackage

// File: hdl/rotating_shift_word_scrambler.sv
// A word passes the input register and then the result register to out_data.
// Throughput: one word per cycle unless out_ready stalls; the input and result
// registers each hold one word, so a word is taken while a finished result waits.
// The rotate, wrap-decrement and checksum add all sit in one stage.
// Reset (rst_n low, synchronous): control registers to zero, no message open,
// both pipeline stages empty; the word registers are not cleared.
// ----------------------------------------------------------------------------
// rotating_shift_word_scrambler: rotating-shift scrambler with checksum
// Rotates each 18-bit word left (encode) or right (decode) by a shift count
// that steps down per word and wraps from min to max. A finish word closes
// the message with a generated or verified two's complement checksum.
// ----------------------------------------------------------------------------
module rotating_shift_word_scrambler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [rsws_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [rsws_pkg::SHIFT_BITS-1:0]      cfg_wdata,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rsws_pkg::in_word_t                   in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rsws_pkg::out_word_t                  out_data
);

  import rsws_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                  decode_mode_r;
  logic [SHIFT_BITS-1:0] start_shift_r;
  logic [SHIFT_BITS-1:0] min_shift_r;
  logic [SHIFT_BITS-1:0] max_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      start_shift_r <= '0;
      min_shift_r   <= '0;
      max_shift_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DECODE_MODE: decode_mode_r <= cfg_wdata[0];
        REG_START_SHIFT: start_shift_r <= cfg_wdata;
        REG_MIN_SHIFT:   min_shift_r   <= cfg_wdata;
        REG_MAX_SHIFT:   max_shift_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register (stage 1) feeds result register (stage 2).
  // Stage 1 moves on whenever stage 2 is empty or being drained this cycle.
  // --------------------------------------------------------------------------
  logic     s1_valid_r;
  in_word_t s1_word_r;
  logic     out_valid_r;
  out_word_t out_word_r;

  logic s1_adv;
  logic in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Message state
  // --------------------------------------------------------------------------
  logic                  in_message_r;
  logic [SHIFT_BITS-1:0] shift_now_r;
  logic [WORD_BITS-1:0]  running_sum_r;

  logic                  in_message_nxt;
  logic [SHIFT_BITS-1:0] shift_now_nxt;
  logic [WORD_BITS-1:0]  running_sum_nxt;

  // Effective state for this word: a closed message restarts from the registers
  logic [SHIFT_BITS-1:0] shift_eff;
  logic [WORD_BITS-1:0]  sum_eff;
  logic [SHIFT_BITS+1:0] seed_sum;
  logic [AMT_BITS-1:0]   amt;
  logic [2*WORD_BITS-1:0] dbl;
  logic [2*WORD_BITS-1:0] dbl_left;
  logic [2*WORD_BITS-1:0] dbl_right;
  logic [WORD_BITS-1:0]  rot_l;
  logic [WORD_BITS-1:0]  rot_r;
  logic [WORD_BITS-1:0]  plain;
  logic [WORD_BITS-1:0]  check_sum;
  logic                  start_bad;
  out_word_t             out_word_nxt;

  always_comb begin
    seed_sum  = {2'b00, start_shift_r} + {2'b00, min_shift_r} + {2'b00, max_shift_r};
    shift_eff = in_message_r ? shift_now_r : start_shift_r;
    sum_eff   = in_message_r ? running_sum_r : WORD_BITS'(seed_sum);

    // Rotate by shifting the word concatenated with itself
    amt       = rot_amount(shift_eff);
    dbl       = {s1_word_r.word_in, s1_word_r.word_in};
    dbl_left  = dbl << amt;
    dbl_right = dbl >> amt;
    rot_l     = dbl_left[2*WORD_BITS-1:WORD_BITS];
    rot_r     = dbl_right[WORD_BITS-1:0];

    // The checksum always covers the unscrambled word
    plain     = decode_mode_r ? rot_r : s1_word_r.word_in;
    check_sum = sum_eff + s1_word_r.word_in;
    start_bad = (start_shift_r < min_shift_r) || (start_shift_r > max_shift_r);

    in_message_nxt  = in_message_r;
    shift_now_nxt   = shift_now_r;
    running_sum_nxt = running_sum_r;
    out_word_nxt.word_out       = '0;
    out_word_nxt.end_of_message = 1'b0;
    out_word_nxt.status         = STAT_OK;

    unique case (s1_word_r.req_type)
      REQ_DATA: begin
        out_word_nxt.word_out = decode_mode_r ? rot_r : rot_l;
        in_message_nxt        = 1'b1;
        running_sum_nxt       = sum_eff + plain;
        // Wrap to max once the count reaches or passes min
        shift_now_nxt         = (shift_eff <= min_shift_r) ? max_shift_r
                                                           : shift_eff - 1'b1;
      end
      REQ_FINISH: begin
        out_word_nxt.end_of_message = 1'b1;
        in_message_nxt              = 1'b0;
        if (decode_mode_r) begin
          if (check_sum != '0) begin
            out_word_nxt.status = STAT_SUM_BAD;
          end
        end else begin
          out_word_nxt.word_out = '0 - sum_eff;
        end
      end
      default: ;
    endcase

    // A bad start count outranks a checksum mismatch
    if (start_bad) begin
      out_word_nxt.status = STAT_START_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_message_r  <= 1'b0;
      shift_now_r   <= '0;
      running_sum_r <= '0;
    end else if (s1_adv) begin
      in_message_r  <= in_message_nxt;
      shift_now_r   <= shift_now_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result register not loaded after stage advance");

  a_finish_closes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_word_r.req_type == REQ_FINISH) |=> !in_message_r)
    else $error("message still open after finish word");

  a_data_opens: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_word_r.req_type == REQ_DATA) |=> in_message_r)
    else $error("message not open after data word");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input refused with empty input register");

  a_decode_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.end_of_message && (out_word_r.status == STAT_SUM_BAD)
      |-> (out_word_r.word_out == '0))
    else $error("checksum mismatch reported with non-zero word");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rotating shift word scrambler
// Runs a short table of directed words and then random messages over a range
// of register settings. Each result is checked against a typed-in word or a
// local model of rotate, wrap and checksum, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import rsws_pkg::*;

  localparam logic [WORD_BITS-1:0] WORD_MASK = 18'h3ffff;
  localparam logic [WORD_BITS-1:0] TOP_BIT   = 18'h20000;
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 60;    // long receiver hold-off
  localparam int PHASE_WORDS   = 50;
  localparam int DIR_COUNT     = 25;

  // Register settings as the bench tracks them
  typedef struct packed {
    logic                  decode;
    logic [SHIFT_BITS-1:0] start_sh;
    logic [SHIFT_BITS-1:0] lo_sh;
    logic [SHIFT_BITS-1:0] hi_sh;
  } shift_cfg_t;

  // One row of the directed table: optional register load, the word to send,
  // and a typed-in result where it is obvious by inspection
  typedef struct packed {
    logic                  set_cfg;
    logic                  dec;
    logic [SHIFT_BITS-1:0] st;
    logic [SHIFT_BITS-1:0] lo;
    logic [SHIFT_BITS-1:0] hi;
    logic                  req;
    logic [WORD_BITS-1:0]  word;
    logic                  fix_check;  // replace word by the correct check word
    logic                  known;
    logic [WORD_BITS-1:0]  x_word;
    logic                  x_eom;
    logic [STAT_BITS-1:0]  x_stat;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // all registers zero, encode: rotate by nothing, count stays at zero
    '{1'b1, 1'b0, 6'd0,  6'd0,  6'd0,  REQ_DATA,   18'h3ffff, 1'b0, 1'b1,
      18'h3ffff, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd0,  6'd0,  6'd0,  REQ_FINISH, 18'h00000, 1'b0, 1'b1,
      18'h00001, 1'b1, STAT_OK},
    // finish straight after finish: empty message, sum of zero
    '{1'b0, 1'b0, 6'd0,  6'd0,  6'd0,  REQ_FINISH, 18'h3ffff, 1'b0, 1'b1,
      18'h00000, 1'b1, STAT_OK},
    '{1'b0, 1'b0, 6'd0,  6'd0,  6'd0,  REQ_DATA,   18'h20000, 1'b0, 1'b1,
      18'h20000, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd0,  6'd0,  6'd0,  REQ_FINISH, 18'h00000, 1'b0, 1'b1,
      18'h20000, 1'b1, STAT_OK},
    // decode, registers zero: good check word, then a bad one
    '{1'b1, 1'b1, 6'd0,  6'd0,  6'd0,  REQ_DATA,   18'h00001, 1'b0, 1'b1,
      18'h00001, 1'b0, STAT_OK},
    '{1'b0, 1'b1, 6'd0,  6'd0,  6'd0,  REQ_FINISH, 18'h3ffff, 1'b0, 1'b1,
      18'h00000, 1'b1, STAT_OK},
    '{1'b0, 1'b1, 6'd0,  6'd0,  6'd0,  REQ_DATA,   18'h12345, 1'b0, 1'b1,
      18'h12345, 1'b0, STAT_OK},
    '{1'b0, 1'b1, 6'd0,  6'd0,  6'd0,  REQ_FINISH, 18'h00000, 1'b0, 1'b1,
      18'h00000, 1'b1, STAT_SUM_BAD},
    // encode, count of 63: rotate amount folds to 63 mod 18
    '{1'b1, 1'b0, 6'd63, 6'd0,  6'd63, REQ_DATA,   18'h00001, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd63, 6'd0,  6'd63, REQ_DATA,   18'h3ffff, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd63, 6'd0,  6'd63, REQ_DATA,   18'h2aaaa, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd63, 6'd0,  6'd63, REQ_FINISH, 18'h3ffff, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    // start below the minimum: flagged on every word
    '{1'b1, 1'b0, 6'd0,  6'd5,  6'd10, REQ_DATA,   18'h15555, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd0,  6'd5,  6'd10, REQ_FINISH, 18'h00000, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    // decode, min above max, start out of range: range flag beats a bad sum
    '{1'b1, 1'b1, 6'd40, 6'd63, 6'd20, REQ_DATA,   18'h20000, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b1, 6'd40, 6'd63, 6'd20, REQ_DATA,   18'h3ffff, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b1, 6'd40, 6'd63, 6'd20, REQ_FINISH, 18'h00001, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    // decode, count equal to the word width: rotate amount of zero
    '{1'b1, 1'b1, 6'd18, 6'd0,  6'd18, REQ_DATA,   18'h0abcd, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b1, 6'd18, 6'd0,  6'd18, REQ_DATA,   18'h3fffe, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b1, 6'd18, 6'd0,  6'd18, REQ_FINISH, 18'h00000, 1'b1, 1'b0,
      18'h0, 1'b0, STAT_OK},
    // encode, tight window: count wraps from the minimum back to the maximum
    '{1'b1, 1'b0, 6'd1,  6'd0,  6'd1,  REQ_DATA,   18'h00003, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd1,  6'd0,  6'd1,  REQ_DATA,   18'h00003, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd1,  6'd0,  6'd1,  REQ_DATA,   18'h00003, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK},
    '{1'b0, 1'b0, 6'd1,  6'd0,  6'd1,  REQ_FINISH, 18'h00000, 1'b0, 1'b0,
      18'h0, 1'b0, STAT_OK}
  };

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [SHIFT_BITS-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  in_word_t                in_data;
  logic                    out_valid;
  logic                    out_ready;
  out_word_t               out_data;

  // Model state: registers as last written and the open message
  shift_cfg_t            settings;
  logic [SHIFT_BITS-1:0] shift_cnt;
  logic [WORD_BITS-1:0]  check_sum;
  logic                  msg_open;

  out_word_t pending_words [$];

  // Handshake between the sender and the receiver for the long hold-off
  bit hold_req;
  bit hold_busy;
  bit calm;        // no idling on either side
  int gap_rate;    // sender idles before a word with odds gap_rate in 10

  int fails;
  int stall_cycles;
  int n_words, n_closes, n_settings, n_checked, n_range_flags, n_sum_flags;

  rotating_shift_word_scrambler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Advance the model by one accepted word and return the result it owes.
  function automatic out_word_t scramble_word(input in_word_t w);
    out_word_t             o;
    logic [35:0]           dbl;
    logic [4:0]            amt;
    logic [WORD_BITS-1:0]  res;
    logic [WORD_BITS-1:0]  plain;
    // First word after reset or after a close opens a new message
    if (!msg_open) begin
      shift_cnt = settings.start_sh;
      check_sum = 18'(settings.start_sh) + 18'(settings.lo_sh) + 18'(settings.hi_sh);
      msg_open  = 1'b1;
    end
    o = '0;
    if (w.req_type == REQ_DATA) begin
      amt = 5'(shift_cnt % 6'd18);
      dbl = {w.word_in, w.word_in};
      if (settings.decode) begin
        res   = dbl[amt +: WORD_BITS];          // rotate right
        plain = res;
      end else begin
        res   = dbl[35 - amt -: WORD_BITS];     // rotate left
        plain = w.word_in;
      end
      check_sum  = check_sum + plain;
      shift_cnt  = (shift_cnt <= settings.lo_sh) ? settings.hi_sh : shift_cnt - 6'd1;
      o.word_out = res;
    end else begin
      o.end_of_message = 1'b1;
      if (settings.decode) begin
        o.word_out = '0;
        if (18'(check_sum + w.word_in) != 18'd0) o.status = STAT_SUM_BAD;
      end else begin
        o.word_out = 18'd0 - check_sum;
      end
      msg_open = 1'b0;
    end
    // Range flag wins over a checksum mismatch
    if (settings.start_sh < settings.lo_sh || settings.start_sh > settings.hi_sh) begin
      o.status = STAT_START_BAD;
    end
    return o;
  endfunction

  // Sum that a close would see right now, message open or not
  function automatic logic [WORD_BITS-1:0] pending_sum();
    if (msg_open) return check_sum;
    return 18'(settings.start_sh) + 18'(settings.lo_sh) + 18'(settings.hi_sh);
  endfunction

  // Bias towards the corner values of a word
  function automatic logic [WORD_BITS-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 18'd0;
      1:       return WORD_MASK;
      2:       return TOP_BIT;
      3:       return 18'd1;
      default: return 18'($urandom);
    endcase
  endfunction

  // Mostly a sane window with the start inside it; now and then anything goes
  function automatic shift_cfg_t rand_cfg(input logic dec);
    shift_cfg_t            c;
    logic [SHIFT_BITS-1:0] a;
    logic [SHIFT_BITS-1:0] b;
    a = 6'($urandom);
    b = 6'($urandom);
    c.decode = dec;
    c.lo_sh  = (a < b) ? a : b;
    c.hi_sh  = (a < b) ? b : a;
    if ($urandom_range(0, 4) == 0) begin
      c.lo_sh = a;
      c.hi_sh = b;
    end
    if ($urandom_range(0, 3) == 0 || c.lo_sh > c.hi_sh) begin
      c.start_sh = 6'($urandom);
    end else begin
      c.start_sh = 6'($urandom_range(c.lo_sh, c.hi_sh));
    end
    return c;
  endfunction

  // Offer one word, hold it until taken, then book the expected result.
  task automatic send_word(input in_word_t w, input bit known, input out_word_t typed);
    out_word_t guess;
    int        gap;
    if (!calm && gap_rate != 0 && $urandom_range(0, 9) < gap_rate) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    guess = scramble_word(w);
    pending_words.push_back(known ? typed : guess);
    n_words++;
    if (w.req_type == REQ_FINISH) n_closes++;
    if (guess.status == STAT_START_BAD) n_range_flags++;
    if (guess.status == STAT_SUM_BAD) n_sum_flags++;
  endtask

  // Drop valid and hold until every booked result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [SHIFT_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  // Registers change only with the block idle
  task automatic load_settings(input shift_cfg_t c);
    drain_results();
    repeat (2) @(negedge clk);
    write_reg(REG_DECODE_MODE, {5'd0, c.decode});
    write_reg(REG_START_SHIFT, c.start_sh);
    write_reg(REG_MIN_SHIFT, c.lo_sh);
    write_reg(REG_MAX_SHIFT, c.hi_sh);
    @(negedge clk);
    cfg_we   <= 1'b0;
    settings  = c;
    n_settings++;
  endtask

  // Random messages under one setting; a close follows every run of data
  // words, and on decode most closes carry the correct check word.
  task automatic run_phase(input shift_cfg_t c, input int n_items, input int rate,
                           input bit with_hold, input bit with_drain);
    int       sent;
    int       len;
    bit       held;
    bit       drained;
    in_word_t w;
    load_settings(c);
    gap_rate = rate;
    sent     = 0;
    held     = 1'b0;
    drained  = 1'b0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 16);
      if (with_drain && !drained && sent >= n_items / 2) begin
        // pause the sender until the block has delivered everything
        drain_results();
        drained = 1'b1;
      end
      if (with_hold && !held && sent >= n_items / 2) begin
        // receiver goes quiet; push words back to back until the input stalls
        hold_req = 1'b1;
        // withdraw the word just taken while the receiver settles
        @(negedge clk);
        in_valid <= 1'b0;
        wait (hold_busy);
        gap_rate = 0;
        len      = 12;
        held     = 1'b1;
      end
      for (int i = 0; i < len; i++) begin
        w.req_type = REQ_DATA;
        w.word_in  = pick_word();
        send_word(w, 1'b0, '0);
      end
      w.req_type = REQ_FINISH;
      w.word_in  = 18'd0 - pending_sum();
      if (!c.decode || $urandom_range(0, 4) == 0) w.word_in = pick_word();
      send_word(w, 1'b0, '0);
      sent    += len + 1;
      gap_rate = rate;
    end
  endtask

  // Receiver: random ready bursts, long hold-off on request, steady when calm
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_busy = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        hold_busy = 1'b0;
      end else if (calm || $urandom_range(0, 7) != 0) begin
        out_ready <= 1'b1;
        for (int i = $urandom_range(1, 20); i > 0 && !hold_req; i--) @(negedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
    end
  end

  // Result checker: every word taken must match the oldest booked one
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (pending_words.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result word %h at %0t", out_data, $realtime);
      end else begin
        want = pending_words.pop_front();
        if (out_data.word_out !== want.word_out ||
            out_data.end_of_message !== want.end_of_message ||
            out_data.status !== want.status) begin
          fails++;
          if (fails <= 10) begin
            $display("result %0d mismatch: got word %h eom %b stat %0d, want word %h eom %b stat %0d",
                     n_checked, out_data.word_out, out_data.end_of_message, out_data.status,
                     want.word_out, want.end_of_message, want.status);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_words.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t  r;
    in_word_t  w;
    out_word_t typed;
    // initialise every input and the model before the first edge
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    hold_req  = 1'b0;
    hold_busy = 1'b0;
    calm      = 1'b0;
    gap_rate  = 3;
    settings  = '0;
    shift_cnt = '0;
    check_sum = '0;
    msg_open  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed table; typed results where obvious, the model otherwise
    foreach (DIR_ROWS[i]) begin
      r = DIR_ROWS[i];
      if (r.set_cfg) load_settings(shift_cfg_t'{r.dec, r.st, r.lo, r.hi});
      w.req_type = r.req;
      w.word_in  = r.fix_check ? 18'd0 - pending_sum() : r.word;
      typed      = '{r.x_word, r.x_eom, r.x_stat};
      send_word(w, r.known, typed);
    end

    // random messages: extremes of the registers first, then random windows
    run_phase(shift_cfg_t'{1'b0, 6'd0, 6'd0, 6'd63}, PHASE_WORDS, 2, 1'b1, 1'b0);
    run_phase(shift_cfg_t'{1'b1, 6'd63, 6'd63, 6'd63}, PHASE_WORDS, 3, 1'b0, 1'b0);
    run_phase(shift_cfg_t'{1'b1, 6'd0, 6'd0, 6'd63}, PHASE_WORDS, 1, 1'b0, 1'b1);
    run_phase(shift_cfg_t'{1'b0, 6'd33, 6'd10, 6'd50}, PHASE_WORDS, 0, 1'b0, 1'b0);
    run_phase(rand_cfg(1'b1), PHASE_WORDS, $urandom_range(0, 4), 1'b0, 1'b0);
    run_phase(rand_cfg(1'b0), PHASE_WORDS, $urandom_range(0, 4), 1'b0, 1'b0);
    run_phase(rand_cfg(1'b1), PHASE_WORDS, $urandom_range(0, 4), 1'b0, 1'b0);
    // last stretch with no idling on either side
    calm = 1'b1;
    run_phase(rand_cfg(1'($urandom)), PHASE_WORDS, 0, 1'b0, 1'b0);

    // let the pipeline empty, then a few spare cycles for stray results
    drain_results();
    repeat (8) @(negedge clk);
    if (pending_words.size() != 0) fails++;

    $display("ran %0d words, %0d message closes, %0d register settings, %0d results checked",
             n_words, n_closes, n_settings, n_checked);
    $display("start-range flags %0d, checksum flags %0d, mismatches %0d",
             n_range_flags, n_sum_flags, fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
